@@ rtl/pft_pkg.sv @@
`timescale 1ns / 1ps

package pft_pkg;

    // field widths
    localparam int POS_W  = 32;
    localparam int QW     = 16;
    localparam int QFRAC  = QW - 2;

    // datapath widths
    localparam int PW     = 2 * QW;                 // quaternion part product
    localparam int TW     = PW + 2;                 // sum of four products
    localparam int MVW    = POS_W + PW;             // matrix entry times coordinate
    localparam int ACC_W  = MVW + 2;                // sum of three of those
    localparam int RW     = ACC_W - 2 * QFRAC;      // rotated coordinate after shift
    localparam int SW     = RW + 1;                 // rotated coordinate plus base

    localparam int NSTG   = 6;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = POS_W;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [QW-1:0]    t_q;
    typedef logic signed [PW-1:0]    t_prod;
    typedef logic signed [TW-1:0]    t_qsum;
    typedef logic signed [MVW-1:0]   t_mv;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [RW-1:0]    t_rot;
    typedef logic signed [SW-1:0]    t_sat;

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
    } t_vec;

    typedef struct packed {
        t_q w;
        t_q x;
        t_q y;
        t_q z;
    } t_quat;

    typedef struct packed {
        t_vec  pos;
        t_quat q;
    } t_base;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } t_pipe_ctl;

    typedef enum logic [CFG_IW-1:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_POS_Z = 3'd2,
        CFG_Q_W   = 3'd3,
        CFG_Q_X   = 3'd4,
        CFG_Q_Y   = 3'd5,
        CFG_Q_Z   = 3'd6
    } t_cfg_idx;

    localparam t_q   Q_ONE   = t_q'(1 << QFRAC);
    localparam t_q   Q_NEG   = t_q'(-(1 << QFRAC));
    localparam t_acc ROT_RND = t_acc'(1) <<< (2 * QFRAC - 1);
    localparam t_qsum Q_RND  = t_qsum'(1) <<< (QFRAC - 1);

    function automatic t_q clamp_q(logic [QW-1:0] raw);
        t_q v;
        v = t_q'(raw);
        if (v > Q_ONE) begin
            return Q_ONE;
        end else if (v < Q_NEG) begin
            return Q_NEG;
        end
        return v;
    endfunction

    // round half up, floor shift, clamp to +-1.0
    function automatic t_q rnd_q(t_qsum t);
        t_qsum s;
        s = (t + Q_RND) >>> QFRAC;
        if (s > t_qsum'(Q_ONE)) begin
            return Q_ONE;
        end else if (s < t_qsum'(Q_NEG)) begin
            return Q_NEG;
        end
        return s[QW-1:0];
    endfunction

    function automatic t_pos sat_pos(t_sat v);
        logic [SW-POS_W:0] top;
        top = v[SW-1:POS_W-1];
        if ((&top) || !(|top)) begin
            return v[POS_W-1:0];
        end
        return v[SW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    // world to body uses the conjugate of the body orientation
    function automatic t_quat conj_q(t_quat q, logic dir);
        t_quat r;
        r = q;
        if (!dir) begin
            r.x = -q.x;
            r.y = -q.y;
            r.z = -q.z;
        end
        return r;
    endfunction

endpackage

@@ rtl/pft_in_if.sv @@
`timescale 1ns / 1ps

interface pft_in_if;
    logic          valid;
    logic          ready;
    logic          func;
    pft_pkg::t_pos pos_x;
    pft_pkg::t_pos pos_y;
    pft_pkg::t_pos pos_z;
    pft_pkg::t_q   in_q_w;
    pft_pkg::t_q   in_q_x;
    pft_pkg::t_q   in_q_y;
    pft_pkg::t_q   in_q_z;

    modport source (
        output valid, func, pos_x, pos_y, pos_z, in_q_w, in_q_x, in_q_y, in_q_z,
        input  ready
    );

    modport sink (
        input  valid, func, pos_x, pos_y, pos_z, in_q_w, in_q_x, in_q_y, in_q_z,
        output ready
    );
endinterface

@@ rtl/pft_out_if.sv @@
`timescale 1ns / 1ps

interface pft_out_if;
    logic          valid;
    logic          ready;
    pft_pkg::t_pos out_pos_x;
    pft_pkg::t_pos out_pos_y;
    pft_pkg::t_pos out_pos_z;
    pft_pkg::t_q   out_q_w;
    pft_pkg::t_q   out_q_x;
    pft_pkg::t_q   out_q_y;
    pft_pkg::t_q   out_q_z;

    modport source (
        output valid, out_pos_x, out_pos_y, out_pos_z,
               out_q_w, out_q_x, out_q_y, out_q_z,
        input  ready
    );

    modport sink (
        input  valid, out_pos_x, out_pos_y, out_pos_z,
               out_q_w, out_q_x, out_q_y, out_q_z,
        output ready
    );
endinterface

@@ rtl/pft_cfg_regs.sv @@
`timescale 1ns / 1ps

module pft_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pft_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [pft_pkg::CFG_DW-1:0]   i_cfg_wdata,
    output pft_pkg::t_base               o_base
);

    pft_pkg::t_base r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base.pos.x <= '0;
            r_base.pos.y <= '0;
            r_base.pos.z <= '0;
            r_base.q.w   <= pft_pkg::Q_ONE;
            r_base.q.x   <= '0;
            r_base.q.y   <= '0;
            r_base.q.z   <= '0;
        end else if (i_cfg_we) begin
            unique case (pft_pkg::t_cfg_idx'(i_cfg_idx))
                pft_pkg::CFG_POS_X: r_base.pos.x <= i_cfg_wdata[pft_pkg::POS_W-1:0];
                pft_pkg::CFG_POS_Y: r_base.pos.y <= i_cfg_wdata[pft_pkg::POS_W-1:0];
                pft_pkg::CFG_POS_Z: r_base.pos.z <= i_cfg_wdata[pft_pkg::POS_W-1:0];
                pft_pkg::CFG_Q_W:   r_base.q.w <=
                    pft_pkg::clamp_q(i_cfg_wdata[pft_pkg::QW-1:0]);
                pft_pkg::CFG_Q_X:   r_base.q.x <=
                    pft_pkg::clamp_q(i_cfg_wdata[pft_pkg::QW-1:0]);
                pft_pkg::CFG_Q_Y:   r_base.q.y <=
                    pft_pkg::clamp_q(i_cfg_wdata[pft_pkg::QW-1:0]);
                pft_pkg::CFG_Q_Z:   r_base.q.z <=
                    pft_pkg::clamp_q(i_cfg_wdata[pft_pkg::QW-1:0]);
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_base = r_base;

endmodule

@@ rtl/pft_pipe_ctrl.sv @@
`timescale 1ns / 1ps

module pft_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output pft_pkg::t_pipe_ctl o_ctl
);

    logic [pft_pkg::NSTG-1:0] r_vld;
    logic [pft_pkg::NSTG-1:0] en;

    // a stage loads when it is empty or its content moves on this cycle
    always_comb begin
        en[pft_pkg::NSTG-1] = !r_vld[pft_pkg::NSTG-1] || i_out_ready;
        for (int k = pft_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < pft_pkg::NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ctl.en  = en;
    assign o_ctl.vld = r_vld;

endmodule

@@ rtl/pft_pos_path.sv @@
`timescale 1ns / 1ps

module pft_pos_path (
    input  logic               i_clk,
    input  pft_pkg::t_pipe_ctl i_ctl,
    input  pft_pkg::t_base     i_base,
    input  logic               i_func,
    input  pft_pkg::t_vec      i_pos,
    output pft_pkg::t_vec      o_pos
);

    // stage 0: translate (world to body), pick rotation quaternion
    pft_pkg::t_vec  r0_v;
    pft_pkg::t_quat r0_qb;
    logic           r0_dir;
    pft_pkg::t_quat qb;

    assign qb = pft_pkg::conj_q(i_base.q, i_func);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r0_qb  <= qb;
            r0_dir <= i_func;
            if (i_func) begin
                r0_v <= i_pos;
            end else begin
                r0_v.x <= pft_pkg::sat_pos(pft_pkg::t_sat'(i_pos.x)
                                         - pft_pkg::t_sat'(i_base.pos.x));
                r0_v.y <= pft_pkg::sat_pos(pft_pkg::t_sat'(i_pos.y)
                                         - pft_pkg::t_sat'(i_base.pos.y));
                r0_v.z <= pft_pkg::sat_pos(pft_pkg::t_sat'(i_pos.z)
                                         - pft_pkg::t_sat'(i_base.pos.z));
            end
        end
    end

    // stage 1: quaternion part products
    pft_pkg::t_prod r1_ww, r1_xx, r1_yy, r1_zz, r1_xy, r1_wz, r1_xz, r1_wy, r1_yz, r1_wx;
    pft_pkg::t_vec  r1_v;
    logic           r1_dir;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r1_ww  <= pft_pkg::t_prod'(r0_qb.w) * pft_pkg::t_prod'(r0_qb.w);
            r1_xx  <= pft_pkg::t_prod'(r0_qb.x) * pft_pkg::t_prod'(r0_qb.x);
            r1_yy  <= pft_pkg::t_prod'(r0_qb.y) * pft_pkg::t_prod'(r0_qb.y);
            r1_zz  <= pft_pkg::t_prod'(r0_qb.z) * pft_pkg::t_prod'(r0_qb.z);
            r1_xy  <= pft_pkg::t_prod'(r0_qb.x) * pft_pkg::t_prod'(r0_qb.y);
            r1_wz  <= pft_pkg::t_prod'(r0_qb.w) * pft_pkg::t_prod'(r0_qb.z);
            r1_xz  <= pft_pkg::t_prod'(r0_qb.x) * pft_pkg::t_prod'(r0_qb.z);
            r1_wy  <= pft_pkg::t_prod'(r0_qb.w) * pft_pkg::t_prod'(r0_qb.y);
            r1_yz  <= pft_pkg::t_prod'(r0_qb.y) * pft_pkg::t_prod'(r0_qb.z);
            r1_wx  <= pft_pkg::t_prod'(r0_qb.w) * pft_pkg::t_prod'(r0_qb.x);
            r1_v   <= r0_v;
            r1_dir <= r0_dir;
        end
    end

    // stage 2: rotation matrix, scaled by |q|^2 for non-unit q
    pft_pkg::t_prod r2_m [3][3];
    pft_pkg::t_vec  r2_v;
    logic           r2_dir;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r2_m[0][0] <= r1_ww + r1_xx - r1_yy - r1_zz;
            r2_m[0][1] <= (r1_xy - r1_wz) <<< 1;
            r2_m[0][2] <= (r1_xz + r1_wy) <<< 1;
            r2_m[1][0] <= (r1_xy + r1_wz) <<< 1;
            r2_m[1][1] <= r1_ww - r1_xx + r1_yy - r1_zz;
            r2_m[1][2] <= (r1_yz - r1_wx) <<< 1;
            r2_m[2][0] <= (r1_xz - r1_wy) <<< 1;
            r2_m[2][1] <= (r1_yz + r1_wx) <<< 1;
            r2_m[2][2] <= r1_ww - r1_xx - r1_yy + r1_zz;
            r2_v       <= r1_v;
            r2_dir     <= r1_dir;
        end
    end

    // stage 3: matrix times vector, nine products
    pft_pkg::t_pos v_a [3];
    pft_pkg::t_mv  r3_mv [3][3];
    logic          r3_dir;

    always_comb begin
        v_a[0] = r2_v.x;
        v_a[1] = r2_v.y;
        v_a[2] = r2_v.z;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_mv[i][j] <= pft_pkg::t_mv'(r2_m[i][j]) * pft_pkg::t_mv'(v_a[j]);
                end
            end
            r3_dir <= r2_dir;
        end
    end

    // stage 4: row sums, round half up, drop fraction of the matrix
    pft_pkg::t_acc acc [3];
    pft_pkg::t_acc acc_sh [3];
    pft_pkg::t_rot r4_r [3];
    logic          r4_dir;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = pft_pkg::t_acc'(r3_mv[i][0]) + pft_pkg::t_acc'(r3_mv[i][1])
                   + pft_pkg::t_acc'(r3_mv[i][2]) + pft_pkg::ROT_RND;
            acc_sh[i] = acc[i] >>> (2 * pft_pkg::QFRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r4_r[i] <= acc_sh[i][pft_pkg::RW-1:0];
            end
            r4_dir <= r3_dir;
        end
    end

    // stage 5: add body origin (body to world), saturate
    pft_pkg::t_pos b_a [3];
    pft_pkg::t_sat fin [3];
    pft_pkg::t_vec r5_pos;

    always_comb begin
        b_a[0] = i_base.pos.x;
        b_a[1] = i_base.pos.y;
        b_a[2] = i_base.pos.z;
        for (int i = 0; i < 3; i++) begin
            if (r4_dir) begin
                fin[i] = pft_pkg::t_sat'(r4_r[i]) + pft_pkg::t_sat'(b_a[i]);
            end else begin
                fin[i] = pft_pkg::t_sat'(r4_r[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r5_pos.x <= pft_pkg::sat_pos(fin[0]);
            r5_pos.y <= pft_pkg::sat_pos(fin[1]);
            r5_pos.z <= pft_pkg::sat_pos(fin[2]);
        end
    end

    assign o_pos = r5_pos;

endmodule

@@ rtl/pft_quat_path.sv @@
`timescale 1ns / 1ps

module pft_quat_path (
    input  logic               i_clk,
    input  pft_pkg::t_pipe_ctl i_ctl,
    input  pft_pkg::t_base     i_base,
    input  logic               i_func,
    input  pft_pkg::t_quat     i_q,
    output pft_pkg::t_quat     o_q
);

    // stage 0: body quaternion (conjugated for world to body), clamp input
    pft_pkg::t_quat qb;
    pft_pkg::t_q    r0_a [4];
    pft_pkg::t_q    r0_b [4];

    assign qb = pft_pkg::conj_q(i_base.q, i_func);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r0_a[0] <= qb.w;
            r0_a[1] <= qb.x;
            r0_a[2] <= qb.y;
            r0_a[3] <= qb.z;
            r0_b[0] <= pft_pkg::clamp_q(i_q.w);
            r0_b[1] <= pft_pkg::clamp_q(i_q.x);
            r0_b[2] <= pft_pkg::clamp_q(i_q.y);
            r0_b[3] <= pft_pkg::clamp_q(i_q.z);
        end
    end

    // stage 1: all sixteen part products
    pft_pkg::t_prod r1_p [4][4];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r1_p[i][j] <= pft_pkg::t_prod'(r0_a[i]) * pft_pkg::t_prod'(r0_b[j]);
                end
            end
        end
    end

    // stage 2: Hamilton product sums
    pft_pkg::t_qsum p [4][4];
    pft_pkg::t_qsum r2_t [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[i][j] = pft_pkg::t_qsum'(r1_p[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r2_t[0] <= p[0][0] - p[1][1] - p[2][2] - p[3][3];
            r2_t[1] <= p[0][1] + p[1][0] + p[2][3] - p[3][2];
            r2_t[2] <= p[0][2] - p[1][3] + p[2][0] + p[3][1];
            r2_t[3] <= p[0][3] + p[1][2] - p[2][1] + p[3][0];
        end
    end

    // stage 3: round and clamp; stages 4 and 5 line up with the position path
    pft_pkg::t_quat r3_q, r4_q, r5_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r3_q.w <= pft_pkg::rnd_q(r2_t[0]);
            r3_q.x <= pft_pkg::rnd_q(r2_t[1]);
            r3_q.y <= pft_pkg::rnd_q(r2_t[2]);
            r3_q.z <= pft_pkg::rnd_q(r2_t[3]);
        end
        if (i_ctl.en[4]) begin
            r4_q <= r3_q;
        end
        if (i_ctl.en[5]) begin
            r5_q <= r4_q;
        end
    end

    assign o_q = r5_q;

endmodule

@@ rtl/pose_frame_transform.sv @@
`timescale 1ns / 1ps

// Pose frame transform between world frame and a body frame.
// i_pose (valid/ready) carries one pose beat: direction func, position
// pos_x/y/z (Q16.16) and orientation in_q_w/x/y/z (Q1.14). o_pose returns
// one beat per input with the transformed position and orientation,
// rounded half up and saturated.
// func = 0: position minus body origin, rotated by the conjugate body
// quaternion; orientation conj(qb)*q. func = 1: position rotated by qb,
// plus body origin; orientation qb*q.
// The body pose is loaded through i_cfg_we/i_cfg_idx/i_cfg_wdata; write it
// only while no beat is in flight. Quaternion values are clamped to +-1.0
// on the way in.
// Six register stages (translate, part products, matrix, 32x32 products,
// row sums, bias add). A beat accepted on i_pose passes through the six
// stages in order and is then offered on o_pose; one beat per cycle is
// sustained while o_pose.ready stays high.
// When the receiver holds o_pose.ready low the result holds and the stages
// behind it keep filling until all six are full; then i_pose.ready drops.
// Reset empties the pipeline and restores identity body pose.
module pose_frame_transform (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pft_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [pft_pkg::CFG_DW-1:0] i_cfg_wdata,
    pft_in_if.sink                     i_pose,
    pft_out_if.source                  o_pose
);

    pft_pkg::t_base     base;
    pft_pkg::t_pipe_ctl ctl;
    pft_pkg::t_vec      in_pos;
    pft_pkg::t_vec      out_pos;
    pft_pkg::t_quat     in_q;
    pft_pkg::t_quat     out_q;

    pft_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_base      (base)
    );

    pft_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pose.valid),
        .i_out_ready (o_pose.ready),
        .o_ctl       (ctl)
    );

    assign in_pos.x = i_pose.pos_x;
    assign in_pos.y = i_pose.pos_y;
    assign in_pos.z = i_pose.pos_z;
    assign in_q.w   = i_pose.in_q_w;
    assign in_q.x   = i_pose.in_q_x;
    assign in_q.y   = i_pose.in_q_y;
    assign in_q.z   = i_pose.in_q_z;

    pft_pos_path u_pos (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_base (base),
        .i_func (i_pose.func),
        .i_pos  (in_pos),
        .o_pos  (out_pos)
    );

    pft_quat_path u_quat (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_base (base),
        .i_func (i_pose.func),
        .i_q    (in_q),
        .o_q    (out_q)
    );

    assign i_pose.ready     = ctl.en[0];
    assign o_pose.valid     = ctl.vld[pft_pkg::NSTG-1];
    assign o_pose.out_pos_x = out_pos.x;
    assign o_pose.out_pos_y = out_pos.y;
    assign o_pose.out_pos_z = out_pos.z;
    assign o_pose.out_q_w   = out_q.w;
    assign o_pose.out_q_x   = out_q.x;
    assign o_pose.out_q_y   = out_q.y;
    assign o_pose.out_q_z   = out_q.z;

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pose.valid)
        else $error("output valid right after reset");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pose.valid && i_pose.ready |=> ctl.vld[0])
        else $error("accepted beat did not enter first stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&ctl.vld) && !o_pose.ready |-> !i_pose.ready)
        else $error("input taken while pipeline full and stalled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pose.valid && o_pose.ready && !ctl.vld[pft_pkg::NSTG-2] |=> !o_pose.valid)
        else $error("result repeated after drain");
`endif

endmodule

@@ test/pose_frame_transform_tb.sv @@
`timescale 1ns / 1ps

module pose_frame_transform_tb;
    import pft_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_POSES  = 150;
    localparam int DRAIN_PAD    = 10;
    localparam int LONG_HOLD    = 200;
    localparam int QUIET_LIMIT  = 4000;
    localparam int NUM_FIELDS   = 7;
    localparam int NUM_REGS     = 7;

    localparam logic [CFG_IW-1:0] CFG_IDX_SPARE = 3'd7;

    localparam longint ONE_Q   = 64'sd1 <<< QFRAC;
    localparam longint POS_HI  = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint POS_LO  = -(64'sd1 <<< (POS_W - 1));
    localparam t_pos   POS_TOP = {1'b0, {(POS_W-1){1'b1}}};
    localparam t_pos   POS_BOT = {1'b1, {(POS_W-1){1'b0}}};

    typedef logic [CFG_DW-1:0] reg_word_t;
    typedef logic [NUM_REGS-1:0][CFG_DW-1:0] base_words_t;

    typedef struct packed {
        logic       func;
        t_pos [2:0] p;
        t_q   [3:0] q;
    } pose_t;

    typedef struct packed {
        t_pos [2:0] p;
        t_q   [3:0] q;
    } result_t;

    typedef struct packed {
        logic [1:0] preset;
        pose_t      stim;
        logic       known;
        result_t    want;
    } probe_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_wdata;

    pft_in_if  in_bus ();
    pft_out_if out_bus ();

    pose_frame_transform uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pose      (in_bus),
        .o_pose      (out_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // body pose as the block should hold it
    longint frame_pos[3];
    longint frame_q[4];

    result_t due_poses[$];
    probe_t  probes[$];
    int      mismatches = 0;
    int      hold_reqs = 0;
    int      quiet_cycles = 0;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint pos_val(t_pos v);
        return longint'(v);
    endfunction

    function automatic longint q_val(t_q v);
        return longint'(v);
    endfunction

    function automatic longint q_clamp(t_q v);
        return clamp_to(longint'(v), -ONE_Q, ONE_Q);
    endfunction

    // add half, then floor shift
    function automatic longint rnd_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic result_t transform_pose(pose_t s);
        longint qb[4];
        longint qi[4];
        longint v[3];
        longint m[3][3];
        longint t[4];
        longint acc;
        result_t res;
        int i;
        qb[0] = frame_q[0];
        for (i = 1; i < 4; i++) begin
            qb[i] = s.func ? frame_q[i] : -frame_q[i];
        end
        for (i = 0; i < 4; i++) begin
            qi[i] = q_clamp(s.q[i]);
        end
        for (i = 0; i < 3; i++) begin
            v[i] = s.func ? pos_val(s.p[i])
                          : clamp_to(pos_val(s.p[i]) - frame_pos[i], POS_LO, POS_HI);
        end
        m[0][0] = qb[0]*qb[0] + qb[1]*qb[1] - qb[2]*qb[2] - qb[3]*qb[3];
        m[0][1] = 2 * (qb[1]*qb[2] - qb[0]*qb[3]);
        m[0][2] = 2 * (qb[1]*qb[3] + qb[0]*qb[2]);
        m[1][0] = 2 * (qb[1]*qb[2] + qb[0]*qb[3]);
        m[1][1] = qb[0]*qb[0] - qb[1]*qb[1] + qb[2]*qb[2] - qb[3]*qb[3];
        m[1][2] = 2 * (qb[2]*qb[3] - qb[0]*qb[1]);
        m[2][0] = 2 * (qb[1]*qb[3] - qb[0]*qb[2]);
        m[2][1] = 2 * (qb[2]*qb[3] + qb[0]*qb[1]);
        m[2][2] = qb[0]*qb[0] - qb[1]*qb[1] - qb[2]*qb[2] + qb[3]*qb[3];
        for (i = 0; i < 3; i++) begin
            acc = rnd_shift(m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2], 2 * QFRAC);
            // body to world adds the origin after rotation, one saturation
            if (s.func) begin
                acc = acc + frame_pos[i];
            end
            res.p[i] = t_pos'(clamp_to(acc, POS_LO, POS_HI));
        end
        t[0] = qb[0]*qi[0] - qb[1]*qi[1] - qb[2]*qi[2] - qb[3]*qi[3];
        t[1] = qb[0]*qi[1] + qb[1]*qi[0] + qb[2]*qi[3] - qb[3]*qi[2];
        t[2] = qb[0]*qi[2] - qb[1]*qi[3] + qb[2]*qi[0] + qb[3]*qi[1];
        t[3] = qb[0]*qi[3] + qb[1]*qi[2] - qb[2]*qi[1] + qb[3]*qi[0];
        for (i = 0; i < 4; i++) begin
            res.q[i] = t_q'(clamp_to(rnd_shift(t[i], QFRAC), -ONE_Q, ONE_Q));
        end
        return res;
    endfunction

    function automatic void note_base_write(logic [CFG_IW-1:0] idx, reg_word_t d);
        case (idx)
            CFG_POS_X: frame_pos[0] = pos_val(d);
            CFG_POS_Y: frame_pos[1] = pos_val(d);
            CFG_POS_Z: frame_pos[2] = pos_val(d);
            CFG_Q_W:   frame_q[0] = q_clamp(d[QW-1:0]);
            CFG_Q_X:   frame_q[1] = q_clamp(d[QW-1:0]);
            CFG_Q_Y:   frame_q[2] = q_clamp(d[QW-1:0]);
            CFG_Q_Z:   frame_q[3] = q_clamp(d[QW-1:0]);
            default: ;
        endcase
    endfunction

    function automatic pose_t mk_pose(logic f, t_pos x, t_pos y, t_pos z,
                                      t_q w, t_q qx, t_q qy, t_q qz);
        pose_t s;
        s.func = f;
        s.p[0] = x;
        s.p[1] = y;
        s.p[2] = z;
        s.q[0] = w;
        s.q[1] = qx;
        s.q[2] = qy;
        s.q[3] = qz;
        return s;
    endfunction

    function automatic result_t mk_result(t_pos x, t_pos y, t_pos z,
                                          t_q w, t_q qx, t_q qy, t_q qz);
        pose_t s;
        s = mk_pose(1'b0, x, y, z, w, qx, qy, qz);
        return {s.p, s.q};
    endfunction

    // quaternion words carry junk above bit QW-1, which the block drops
    function automatic base_words_t mk_base(t_pos x, t_pos y, t_pos z,
                                            t_q w, t_q qx, t_q qy, t_q qz);
        base_words_t b;
        b[CFG_POS_X] = x;
        b[CFG_POS_Y] = y;
        b[CFG_POS_Z] = z;
        b[CFG_Q_W] = {(CFG_DW-QW)'($urandom()), w};
        b[CFG_Q_X] = {(CFG_DW-QW)'($urandom()), qx};
        b[CFG_Q_Y] = {(CFG_DW-QW)'($urandom()), qy};
        b[CFG_Q_Z] = {(CFG_DW-QW)'($urandom()), qz};
        return b;
    endfunction

    function automatic t_pos rand_pos();
        case ($urandom_range(0, 9))
            0: return POS_TOP;
            1: return POS_BOT;
            2, 3, 4: return t_pos'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return t_pos'($urandom());
        endcase
    endfunction

    function automatic t_q rand_q();
        case ($urandom_range(0, 9))
            0: return Q_ONE;
            1: return Q_NEG;
            2: return '0;
            3: return t_q'($urandom());
            default: return t_q'(int'($urandom_range(0, 2 << QFRAC)) - (1 << QFRAC));
        endcase
    endfunction

    function automatic pose_t rand_pose();
        return mk_pose(1'($urandom()), rand_pos(), rand_pos(), rand_pos(),
                       rand_q(), rand_q(), rand_q(), rand_q());
    endfunction

    function automatic base_words_t rand_base();
        if ($urandom_range(0, 5) == 0) begin
            return mk_base('0, '0, '0, Q_ONE, '0, '0, '0);
        end
        return mk_base(rand_pos(), rand_pos(), rand_pos(),
                       rand_q(), rand_q(), rand_q(), rand_q());
    endfunction

    function automatic void add_probe(logic [1:0] preset, pose_t s, logic known,
                                      result_t w);
        probe_t pr;
        pr.preset = preset;
        pr.stim = s;
        pr.known = known;
        pr.want = w;
        probes.push_back(pr);
    endfunction

    function automatic longint field_of(result_t r, int i);
        return (i < 3) ? pos_val(r.p[i]) : q_val(r.q[i-3]);
    endfunction

    function automatic string field_name(int i);
        case (i)
            0: return "out_pos_x";
            1: return "out_pos_y";
            2: return "out_pos_z";
            3: return "out_q_w";
            4: return "out_q_x";
            5: return "out_q_y";
            default: return "out_q_z";
        endcase
    endfunction

    // call at a rising edge; returns at the edge that takes the beat
    task automatic put_pose(input pose_t s, input logic known, input result_t w);
        in_bus.valid  <= 1'b1;
        in_bus.func   <= s.func;
        in_bus.pos_x  <= s.p[0];
        in_bus.pos_y  <= s.p[1];
        in_bus.pos_z  <= s.p[2];
        in_bus.in_q_w <= s.q[0];
        in_bus.in_q_x <= s.q[1];
        in_bus.in_q_y <= s.q[2];
        in_bus.in_q_z <= s.q[3];
        @(negedge i_clk);
        while (!in_bus.ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        due_poses.push_back(known ? w : transform_pose(s));
    endtask

    task automatic settle();
        while (due_poses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic load_base(input base_words_t b);
        reg_word_t junk;
        int i;
        for (i = 0; i < NUM_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_wdata <= b[i];
            @(posedge i_clk);
            note_base_write(t_cfg_idx'(i), b[i]);
        end
        // unmapped index must leave the body pose alone
        junk = $urandom();
        i_cfg_idx   <= CFG_IDX_SPARE;
        i_cfg_wdata <= junk;
        @(posedge i_clk);
        note_base_write(CFG_IDX_SPARE, junk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pump_poses(input int n, input bit tight);
        int k;
        int burst;
        int gap;
        burst = 0;
        for (k = 0; k < n; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = tight ? 0 : $urandom_range(0, 6);
                if (gap != 0) begin
                    in_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst--;
            put_pose(rand_pose(), 1'b0, '0);
        end
        in_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        base_words_t presets[3];
        logic [1:0] cur_preset;
        int ph;
        int i;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        in_bus.valid  = 1'b0;
        in_bus.func   = 1'b0;
        in_bus.pos_x  = '0;
        in_bus.pos_y  = '0;
        in_bus.pos_z  = '0;
        in_bus.in_q_w = '0;
        in_bus.in_q_x = '0;
        in_bus.in_q_y = '0;
        in_bus.in_q_z = '0;
        frame_pos = '{0, 0, 0};
        frame_q   = '{ONE_Q, 0, 0, 0};

        presets[0] = mk_base('0, '0, '0, Q_ONE, '0, '0, '0);
        // extreme origin, non-unit and over-range orientation words
        presets[1] = mk_base(POS_TOP, POS_BOT, POS_TOP,
                             16'sh7FFF, 16'sh8000, 16'sh4000, -16'sd16384);
        // quarter turn about z, small offset
        presets[2] = mk_base(32'h0003_0000, 32'hFFFE_8000, 32'h0000_0001,
                             16'sd11585, '0, '0, 16'sd11585);

        // identity body pose: output equals input with quaternion clamped
        add_probe(0, mk_pose(0, 0, 0, 0, Q_ONE, 0, 0, 0), 1,
                  mk_result(0, 0, 0, Q_ONE, 0, 0, 0));
        add_probe(0, mk_pose(1, POS_TOP, POS_TOP, POS_TOP, 0, Q_ONE, 0, 0), 1,
                  mk_result(POS_TOP, POS_TOP, POS_TOP, 0, Q_ONE, 0, 0));
        add_probe(0, mk_pose(0, POS_BOT, POS_BOT, POS_BOT, Q_NEG, 0, 0, 0), 1,
                  mk_result(POS_BOT, POS_BOT, POS_BOT, Q_NEG, 0, 0, 0));
        add_probe(0, mk_pose(1, 1, -1, 32'h0001_0000,
                             16'sh7FFF, 16'sh8000, 16'sh4001, 16'shBFFF), 1,
                  mk_result(1, -1, 32'h0001_0000, Q_ONE, Q_NEG, Q_ONE, Q_NEG));
        add_probe(0, mk_pose(0, POS_BOT, POS_TOP, 32'h1234_5678, 0, 0, Q_NEG, Q_ONE), 1,
                  mk_result(POS_BOT, POS_TOP, 32'h1234_5678, 0, 0, Q_NEG, Q_ONE));
        add_probe(0, mk_pose(1, 32'h0001_8000, 32'hFFFF_0000, 0,
                             8192, -8192, 8192, -8192), 1,
                  mk_result(32'h0001_8000, 32'hFFFF_0000, 0, 8192, -8192, 8192, -8192));
        add_probe(1, mk_pose(0, POS_BOT, POS_TOP, POS_BOT, Q_ONE, 0, 0, 0), 0, '0);
        add_probe(1, mk_pose(1, POS_TOP, POS_TOP, POS_TOP, 0, 0, 0, Q_ONE), 0, '0);
        add_probe(1, mk_pose(1, POS_BOT, POS_BOT, POS_BOT, Q_NEG, Q_NEG, Q_NEG, Q_NEG),
                  0, '0);
        add_probe(1, mk_pose(0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000),
                  0, '0);
        add_probe(1, mk_pose(0, 1, -1, 32'h0001_0000, Q_ONE, Q_ONE, Q_ONE, Q_ONE), 0, '0);
        add_probe(1, mk_pose(1, 0, 1, -1, 0, 0, 0, 0), 0, '0);
        add_probe(2, mk_pose(1, 32'h0001_0000, 0, 0, Q_ONE, 0, 0, 0), 0, '0);
        add_probe(2, mk_pose(0, 32'h0003_0000, 32'hFFFE_8000, 1, 11585, 0, 0, 11585),
                  0, '0);
        add_probe(2, mk_pose(0, POS_TOP, POS_BOT, 0, 0, Q_ONE, 0, 0), 0, '0);
        add_probe(2, mk_pose(1, 32'h0012_3456, 32'hFFED_CBA9, 32'h7FFF_0000,
                             -11585, 0, 11585, 0), 0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_preset = 0;
        for (i = 0; i < probes.size(); i++) begin
            if (probes[i].preset != cur_preset) begin
                in_bus.valid <= 1'b0;
                settle();
                load_base(presets[probes[i].preset]);
                cur_preset = probes[i].preset;
            end
            put_pose(probes[i].stim, probes[i].known, probes[i].want);
        end
        in_bus.valid <= 1'b0;

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            load_base(rand_base());
            if (ph % 4 == 2) begin
                // hold the output off while poses keep coming
                @(negedge i_clk);
                hold_reqs++;
                @(posedge i_clk);
            end
            pump_poses(PHASE_POSES, ph % 4 != 0);
        end

        settle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : result_sink
        int mode;
        int left;
        int holds_done;
        out_bus.ready = 1'b0;
        mode = 0;
        left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_reqs) begin
                holds_done = hold_reqs;
                out_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_bus.ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 60);
                end
                left--;
                case (mode)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= ($urandom_range(0, 3) != 0);
                    2: out_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: out_bus.ready <= !out_bus.ready;
                endcase
            end
        end
    end

    // handshakes are sampled mid-cycle, ahead of the edge that takes the beat
    always @(negedge i_clk) begin : check_out
        result_t got;
        result_t want;
        int i;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.p[0] = out_bus.out_pos_x;
            got.p[1] = out_bus.out_pos_y;
            got.p[2] = out_bus.out_pos_z;
            got.q[0] = out_bus.out_q_w;
            got.q[1] = out_bus.out_q_x;
            got.q[2] = out_bus.out_q_y;
            got.q[3] = out_bus.out_q_z;
            if (due_poses.size() == 0) begin
                $error("o_pose beat with no pose outstanding");
                mismatches++;
            end else begin
                want = due_poses.pop_front();
                for (i = 0; i < NUM_FIELDS; i++) begin
                    if (field_of(got, i) != field_of(want, i)) begin
                        $error("%s: expected %0d, got %0d", field_name(i),
                               field_of(want, i), field_of(got, i));
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : watchdog
        if (!i_rst_n || (in_bus.valid && in_bus.ready) ||
            (out_bus.valid && out_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
rtl/pft_pkg.sv
rtl/pft_in_if.sv
rtl/pft_out_if.sv
rtl/pft_cfg_regs.sv
rtl/pft_pipe_ctrl.sv
rtl/pft_pos_path.sv
rtl/pft_quat_path.sv
rtl/pose_frame_transform.sv
test/pose_frame_transform_tb.sv
